// File: sv/double_ended_queue_defines.svh
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH   = 64;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_ELEM  = 2'd3;

  // What one cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_t;

  // What the whole chain does in a cycle.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_SHIFT_OUT,
    CMD_ROTATE
  } chain_cmd_t;

  typedef struct packed {
    chain_cmd_t       cmd;
    logic [CNT_W-1:0] count;
  } chain_ctrl_t;

  function automatic logic [CNT_W-1:0] to_cnt(int v);
    return v[CNT_W-1:0];
  endfunction

  localparam logic [CNT_W-1:0] CNT_FULL = to_cnt(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = to_cnt(1);

endpackage

// File: sv/double_ended_queue.sv
// Push and pop: one beat in, one status beat out on the cycle after the accept; busy stays low,
// so a new command can be taken every cycle.
// Dump: one element beat per stored entry, the first on the cycle after the accept, one a cycle
// as the cell chain rotates once; busy is high until the last beat. An empty dump gives one beat.
// The receiver cannot stall: every result is a single-cycle strobe on out_valid.
// Synchronous active-low reset empties the queue; cell contents are not cleared.
`include "double_ended_queue_defines.svh"

module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_opcode,
  input  logic signed [dq_pkg::VAL_W-1:0]   in_item_value,
  output logic                              out_valid,
  output logic signed [dq_pkg::VAL_W-1:0]   out_value,
  output logic [1:0]                        out_status,
  output logic                              out_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  logic [dq_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [dq_pkg::CNT_W-1:0]        idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic signed [dq_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;
  logic                            out_last_r, out_last_nxt;

  dq_pkg::chain_ctrl_t             ctrl;
  logic signed [dq_pkg::VAL_W-1:0] head_val;
  logic                            accept;
  logic                            is_full;
  logic                            is_empty;
  logic                            fpush_ok;

  assign busy     = (state_r == ST_DUMP);
  assign accept   = start && !busy;
  assign is_full  = (count_r == dq_pkg::CNT_FULL);
  assign is_empty = (count_r == '0);
  assign fpush_ok = accept && (in_opcode == dq_pkg::OP_PUSH_FRONT) && !is_full;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = dq_pkg::STAT_OK;
    out_last_nxt   = 1'b1;
    ctrl.cmd       = dq_pkg::CMD_HOLD;
    ctrl.count     = count_r;

    if (state_r == ST_DUMP) begin
      ctrl.cmd       = dq_pkg::CMD_ROTATE;
      out_valid_nxt  = 1'b1;
      out_value_nxt  = head_val;
      out_status_nxt = dq_pkg::STAT_ELEM;
      out_last_nxt   = (idx_r == count_r - dq_pkg::CNT_ONE);
      idx_nxt        = idx_r + dq_pkg::CNT_ONE;
      if (out_last_nxt) begin
        state_nxt = ST_IDLE;
      end
    end else if (accept) begin
      case (in_opcode)
        dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
          out_valid_nxt = 1'b1;
          if (is_full) begin
            out_status_nxt = dq_pkg::STAT_FULL;
          end else begin
            ctrl.cmd  = (in_opcode == dq_pkg::OP_PUSH_FRONT) ? dq_pkg::CMD_PUSH_FRONT
                                                             : dq_pkg::CMD_PUSH_BACK;
            count_nxt = count_r + dq_pkg::CNT_ONE;
          end
        end
        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
          out_valid_nxt = 1'b1;
          if (is_empty) begin
            out_status_nxt = dq_pkg::STAT_EMPTY;
          end else begin
            // A back pop only shortens the count; the stale cell is never read again.
            if (in_opcode == dq_pkg::OP_POP_FRONT) begin
              ctrl.cmd = dq_pkg::CMD_SHIFT_OUT;
            end
            count_nxt = count_r - dq_pkg::CNT_ONE;
          end
        end
        dq_pkg::OP_DUMP: begin
          out_valid_nxt = 1'b1;
          if (is_empty) begin
            out_status_nxt = dq_pkg::STAT_EMPTY;
          end else begin
            // The head is taken in the accept cycle; its beat shows on the next cycle.
            ctrl.cmd       = dq_pkg::CMD_ROTATE;
            out_value_nxt  = head_val;
            out_status_nxt = dq_pkg::STAT_ELEM;
            out_last_nxt   = (count_r == dq_pkg::CNT_ONE);
            idx_nxt        = dq_pkg::CNT_ONE;
            if (!out_last_nxt) begin
              state_nxt = ST_DUMP;
            end
          end
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  dq_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .wr_val   (in_item_value),
    .head_val (head_val)
  );

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  `DQ_ASSERT(a_count_bound, count_r <= dq_pkg::CNT_FULL, "entry count above depth")
  `DQ_ASSERT(a_dump_nonempty, busy |-> (count_r != '0) && (idx_r < count_r), "dump out of range")
  `DQ_ASSERT(a_dump_count_stable, busy |=> $stable(count_r), "count moved during dump")
  `DQ_ASSERT(a_push_grows, fpush_ok |=> count_r == $past(count_r) + dq_pkg::CNT_ONE, "push lost")
  `DQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !busy, "activity right after reset")

endmodule

// File: sv/dq_cell.sv
module dq_cell (
  input  logic                              clk,
  input  dq_pkg::cell_op_t                  op,
  input  logic signed [dq_pkg::VAL_W-1:0]   left_val,
  input  logic signed [dq_pkg::VAL_W-1:0]   right_val,
  input  logic signed [dq_pkg::VAL_W-1:0]   load_val,
  output logic signed [dq_pkg::VAL_W-1:0]   val_r
);

  logic signed [dq_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    case (op)
      dq_pkg::CELL_FROM_LEFT:  val_nxt = left_val;
      dq_pkg::CELL_FROM_RIGHT: val_nxt = right_val;
      dq_pkg::CELL_LOAD:       val_nxt = load_val;
      default:                 val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: sv/dq_chain.sv
module dq_chain (
  input  logic                              clk,
  input  dq_pkg::chain_ctrl_t               ctrl,
  input  logic signed [dq_pkg::VAL_W-1:0]   wr_val,
  output logic signed [dq_pkg::VAL_W-1:0]   head_val
);

  logic signed [dq_pkg::VAL_W-1:0] cell_val [dq_pkg::DEPTH];
  logic [dq_pkg::CNT_W-1:0]        tail_pos;

  // The entry at the back sits one cell below the count.
  assign tail_pos = ctrl.count - dq_pkg::CNT_ONE;
  assign head_val = cell_val[0];

  for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
    localparam logic [dq_pkg::CNT_W-1:0] CELL_IDX = dq_pkg::to_cnt(i);

    dq_pkg::cell_op_t                op;
    logic signed [dq_pkg::VAL_W-1:0] left_val;
    logic signed [dq_pkg::VAL_W-1:0] right_val;
    logic signed [dq_pkg::VAL_W-1:0] load_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_val = cell_val[i-1];
    end

    if (i == dq_pkg::DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner_r
      assign right_val = cell_val[i+1];
    end

    // While rotating, the head wraps around into the back cell.
    assign load_val = (ctrl.cmd == dq_pkg::CMD_ROTATE) ? cell_val[0] : wr_val;

    always_comb begin
      case (ctrl.cmd)
        dq_pkg::CMD_PUSH_FRONT:
          op = (i == 0) ? dq_pkg::CELL_LOAD : dq_pkg::CELL_FROM_LEFT;
        dq_pkg::CMD_PUSH_BACK:
          op = (CELL_IDX == ctrl.count) ? dq_pkg::CELL_LOAD : dq_pkg::CELL_HOLD;
        dq_pkg::CMD_SHIFT_OUT:
          op = dq_pkg::CELL_FROM_RIGHT;
        dq_pkg::CMD_ROTATE:
          op = (CELL_IDX == tail_pos) ? dq_pkg::CELL_LOAD : dq_pkg::CELL_FROM_RIGHT;
        default:
          op = dq_pkg::CELL_HOLD;
      endcase
    end

    dq_cell u_cell (
      .clk       (clk),
      .op        (op),
      .left_val  (left_val),
      .right_val (right_val),
      .load_val  (load_val),
      .val_r     (cell_val[i])
    );
  end

endmodule
